/* design/sacl_pkg.sv */
// Package for the set-associative LRU cache: sizes, codes, payload and set-row types.
// Used by sacl_ram's parent set_assoc_cache_lru_sim; depends on nothing else.
package sacl_pkg;

    localparam int MAX_SET_BITS   = 5;
    localparam int NUM_WAYS       = 4;
    localparam int ADDR_WIDTH     = 32;

    localparam int ADDRESS_W      = 32;
    localparam int COUNT_W        = 32;
    localparam int SET_BITS_CFG_W = 3;
    localparam int WAYS_CFG_W     = 3;
    localparam int BLOCK_CFG_W    = 4;
    localparam int CFG_DATA_W     = 4;
    localparam int CFG_INDEX_W    = 2;
    localparam int BLOCK_BITS_MAX = 9;

    localparam int SET_COUNT = 1 << MAX_SET_BITS;
    localparam int SET_W     = MAX_SET_BITS;
    localparam int SB_W      = $clog2(MAX_SET_BITS + 1);
    localparam int WAYS_CW   = $clog2(NUM_WAYS + 1);
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int RANK_W    = WAY_W;
    localparam int RANK_MAX  = NUM_WAYS - 1;
    localparam int TAG_W     = ADDR_WIDTH - 2;

    localparam logic [ADDRESS_W-1:0] ADDR_MASK =
        (ADDR_WIDTH >= ADDRESS_W) ? {ADDRESS_W{1'b1}}
                                  : ADDRESS_W'((64'd1 << ADDR_WIDTH) - 64'd1);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_IFETCH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_MISS  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_WAYS_IN_USE = 2'd1,
        CFG_BLOCK_BITS  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SECOND
    } state_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [ADDRESS_W-1:0] address;
    } cache_in_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] eviction_total;
        logic               last_of_item;
    } cache_out_t;

    typedef struct packed {
        logic [NUM_WAYS-1:0]             valid;
        logic [NUM_WAYS-1:0][TAG_W-1:0]  tag;
        logic [NUM_WAYS-1:0][RANK_W-1:0] rank;
    } set_row_t;

endpackage

/* design/sacl_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Stands alone; holds one word per address, and the read data is registered.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/set_assoc_cache_lru_sim.sv */
// Top level of the set-associative cache with LRU replacement.
// Depends on sacl_pkg for types and sizes and on sacl_ram for the set store.
//
// Each set is one row of a synchronous RAM holding the valid bits, tags and
// recency ranks of all its ways. For a load or store, the transfer issues
// the row read, and the lookup state then looks the tag up, writes the
// updated row back and loads the result register. A modify then goes to a
// second state, its second access working on the row it has just written,
// and an instruction fetch is taken while idle and gives no result. A new
// transfer is taken while the last result still waits to be collected; a
// lookup holds until the result register is free. Rows come out of reset
// reading as empty without any clearing pass, so the block is ready at once.
module set_assoc_cache_lru_sim (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  sacl_pkg::cache_in_t              in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output sacl_pkg::cache_out_t             out_data,
    input  logic                             cfg_write,
    input  logic [sacl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    sacl_pkg::state_t state_reg, state_next;

    logic [sacl_pkg::SET_BITS_CFG_W-1:0] set_bits_reg;
    logic [sacl_pkg::WAYS_CFG_W-1:0]     ways_in_use_reg;
    logic [sacl_pkg::BLOCK_CFG_W-1:0]    block_bits_reg;

    logic [sacl_pkg::SB_W-1:0]        sb_eff;
    logic [sacl_pkg::WAYS_CW-1:0]     ways_eff;
    logic [sacl_pkg::BLOCK_CFG_W-1:0] bb_eff;

    logic [sacl_pkg::ADDRESS_W-1:0] addr_shifted;
    logic [sacl_pkg::ADDRESS_W-1:0] tag_full;
    logic [sacl_pkg::SET_W-1:0]     set_mask;
    logic [sacl_pkg::SET_W-1:0]     in_set;
    logic [sacl_pkg::TAG_W-1:0]     in_tag;

    logic [1:0]                 op_reg;
    logic [sacl_pkg::SET_W-1:0] set_reg;
    logic [sacl_pkg::TAG_W-1:0] tag_reg;

    logic [sacl_pkg::SET_COUNT-1:0] row_valid_reg;
    sacl_pkg::set_row_t             fwd_reg;
    sacl_pkg::set_row_t             ram_rdata;
    sacl_pkg::set_row_t             row_cur;
    sacl_pkg::set_row_t             row_new;

    logic [sacl_pkg::COUNT_W-1:0] hits_reg, hits_next;
    logic [sacl_pkg::COUNT_W-1:0] misses_reg, misses_next;
    logic [sacl_pkg::COUNT_W-1:0] evicts_reg, evicts_next;

    logic                 out_valid_reg;
    sacl_pkg::cache_out_t out_data_reg;

    logic in_fire;
    logic out_free;
    logic busy;
    logic commit;
    logic ram_re;

    logic                        hit;
    logic                        any_inv;
    logic [sacl_pkg::WAY_W-1:0]  hit_way;
    logic [sacl_pkg::WAY_W-1:0]  inv_way;
    logic [sacl_pkg::WAY_W-1:0]  victim;
    logic [sacl_pkg::RANK_W-1:0] best_rank;
    logic [sacl_pkg::WAY_W-1:0]  way_sel;
    logic [sacl_pkg::RANK_W-1:0] old_rank;
    logic                        filling;
    logic [1:0]                  outcome;

    // Configuration, saturated to the legal ranges.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= sacl_pkg::SET_BITS_CFG_W'(1);
            ways_in_use_reg <= sacl_pkg::WAYS_CFG_W'(1);
            block_bits_reg  <= sacl_pkg::BLOCK_CFG_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sacl_pkg::CFG_SET_BITS:
                begin
                    set_bits_reg <= cfg_data[sacl_pkg::SET_BITS_CFG_W-1:0];
                end
                sacl_pkg::CFG_WAYS_IN_USE:
                begin
                    ways_in_use_reg <= cfg_data[sacl_pkg::WAYS_CFG_W-1:0];
                end
                sacl_pkg::CFG_BLOCK_BITS:
                begin
                    block_bits_reg <= cfg_data[sacl_pkg::BLOCK_CFG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (set_bits_reg == '0)
        begin
            sb_eff = sacl_pkg::SB_W'(1);
        end
        else if (32'(set_bits_reg) > sacl_pkg::MAX_SET_BITS)
        begin
            sb_eff = sacl_pkg::SB_W'(sacl_pkg::MAX_SET_BITS);
        end
        else
        begin
            sb_eff = sacl_pkg::SB_W'(set_bits_reg);
        end

        if (ways_in_use_reg == '0)
        begin
            ways_eff = sacl_pkg::WAYS_CW'(1);
        end
        else if (32'(ways_in_use_reg) > sacl_pkg::NUM_WAYS)
        begin
            ways_eff = sacl_pkg::WAYS_CW'(sacl_pkg::NUM_WAYS);
        end
        else
        begin
            ways_eff = sacl_pkg::WAYS_CW'(ways_in_use_reg);
        end

        if (block_bits_reg == '0)
        begin
            bb_eff = sacl_pkg::BLOCK_CFG_W'(1);
        end
        else if (32'(block_bits_reg) > sacl_pkg::BLOCK_BITS_MAX)
        begin
            bb_eff = sacl_pkg::BLOCK_CFG_W'(sacl_pkg::BLOCK_BITS_MAX);
        end
        else
        begin
            bb_eff = block_bits_reg;
        end
    end

    // Address split into set and tag.
    always_comb
    begin
        addr_shifted = (in_data.address & sacl_pkg::ADDR_MASK) >> bb_eff;
        set_mask     = ~({sacl_pkg::SET_W{1'b1}} << sb_eff);
        in_set       = addr_shifted[sacl_pkg::SET_W-1:0] & set_mask;
        tag_full     = addr_shifted >> sb_eff;
        in_tag       = sacl_pkg::TAG_W'(tag_full);
    end

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign busy     = (state_reg == sacl_pkg::ST_LOOKUP) || (state_reg == sacl_pkg::ST_SECOND);
    assign commit   = busy && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sacl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sacl_pkg::ST_IDLE:
            begin
                if (in_fire && (in_data.operation != sacl_pkg::OP_IFETCH))
                begin
                    state_next = sacl_pkg::ST_LOOKUP;
                end
            end
            sacl_pkg::ST_LOOKUP:
            begin
                if (commit)
                begin
                    state_next = (op_reg == sacl_pkg::OP_MODIFY) ? sacl_pkg::ST_SECOND
                                                                 : sacl_pkg::ST_IDLE;
                end
            end
            sacl_pkg::ST_SECOND:
            begin
                if (commit)
                begin
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sacl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        ram_re   = 1'b0;
        case (state_reg)
            sacl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                ram_re   = in_valid && (in_data.operation != sacl_pkg::OP_IFETCH);
            end
            sacl_pkg::ST_LOOKUP:
            begin
            end
            sacl_pkg::ST_SECOND:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= in_data.operation;
            set_reg <= in_set;
            tag_reg <= in_tag;
        end
        if (commit)
        begin
            fwd_reg <= row_new;
        end
    end

    sacl_ram #(
        .WIDTH ($bits(sacl_pkg::set_row_t)),
        .DEPTH (sacl_pkg::SET_COUNT)
    ) u_set_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (set_reg),
        .wdata (row_new),
        .re    (ram_re),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (commit)
        begin
            row_valid_reg[set_reg] <= 1'b1;
        end
    end

    // Lookup, replacement choice and recency update over one set row.
    always_comb
    begin
        if (state_reg == sacl_pkg::ST_SECOND)
        begin
            row_cur = fwd_reg;
        end
        else if (row_valid_reg[set_reg])
        begin
            row_cur = ram_rdata;
        end
        else
        begin
            row_cur = '0;
        end

        hit       = 1'b0;
        any_inv   = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        victim    = '0;
        best_rank = row_cur.rank[0];
        for (int i = 0; i < sacl_pkg::NUM_WAYS; i++)
        begin
            if (sacl_pkg::WAYS_CW'(i) < ways_eff)
            begin
                if (!hit && row_cur.valid[i] && (row_cur.tag[i] == tag_reg))
                begin
                    hit     = 1'b1;
                    hit_way = sacl_pkg::WAY_W'(i);
                end
                if (!any_inv && !row_cur.valid[i])
                begin
                    any_inv = 1'b1;
                    inv_way = sacl_pkg::WAY_W'(i);
                end
                if (row_cur.rank[i] > best_rank)
                begin
                    best_rank = row_cur.rank[i];
                    victim    = sacl_pkg::WAY_W'(i);
                end
            end
        end

        filling = !hit && any_inv;
        if (hit)
        begin
            way_sel = hit_way;
            outcome = sacl_pkg::OUT_HIT;
        end
        else if (any_inv)
        begin
            way_sel = inv_way;
            outcome = sacl_pkg::OUT_MISS;
        end
        else
        begin
            way_sel = victim;
            outcome = sacl_pkg::OUT_EVICT;
        end
        old_rank = row_cur.rank[way_sel];

        row_new = row_cur;
        for (int i = 0; i < sacl_pkg::NUM_WAYS; i++)
        begin
            if ((sacl_pkg::WAYS_CW'(i) < ways_eff) && (sacl_pkg::WAY_W'(i) != way_sel)
                && row_cur.valid[i] && (filling || (row_cur.rank[i] < old_rank))
                && (32'(row_cur.rank[i]) < sacl_pkg::RANK_MAX))
            begin
                row_new.rank[i] = row_cur.rank[i] + sacl_pkg::RANK_W'(1);
            end
        end
        row_new.rank[way_sel] = '0;
        if (!hit)
        begin
            row_new.valid[way_sel] = 1'b1;
            row_new.tag[way_sel]   = tag_reg;
        end

        hits_next   = hits_reg + sacl_pkg::COUNT_W'(hit);
        misses_next = misses_reg + sacl_pkg::COUNT_W'(!hit);
        evicts_next = evicts_reg + sacl_pkg::COUNT_W'(!hit && !any_inv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            evicts_reg    <= evicts_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg.outcome        <= outcome;
            out_data_reg.hit_total      <= hits_next;
            out_data_reg.miss_total     <= misses_next;
            out_data_reg.eviction_total <= evicts_next;
            out_data_reg.last_of_item   <= !((state_reg == sacl_pkg::ST_LOOKUP)
                                             && (op_reg == sacl_pkg::OP_MODIFY));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Every access counts exactly one hit or one miss.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (hits_reg + misses_reg) == ($past(hits_reg) + $past(misses_reg) + 32'd1))
        else $error("Access did not count exactly one hit or miss.");

    // Totals only move when a lookup commits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(hits_reg) && $stable(misses_reg) && $stable(evicts_reg))
        else $error("Totals changed without a committed access.");

    // A committed lookup always leaves a result waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("Committed access produced no result.");

    // A written set reads back as initialised afterwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> row_valid_reg[$past(set_reg)])
        else $error("Written set not marked as initialised.");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Testbench for set_assoc_cache_lru_sim: directed and random access traffic, with results
// predicted by an in-bench LRU cache and checked on every result transfer. Depends on sacl_pkg.
module testbench;

    localparam int LINES = sacl_pkg::SET_COUNT * sacl_pkg::NUM_WAYS;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    sacl_pkg::cache_in_t              in_data;
    logic                             out_valid;
    logic                             out_ready;
    sacl_pkg::cache_out_t             out_data;
    logic                             cfg_write;
    logic [sacl_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data;

    logic                             cached_valid [LINES];
    logic [sacl_pkg::TAG_W-1:0]       cached_tag [LINES];
    logic [sacl_pkg::RANK_W-1:0]      cached_rank [LINES];
    logic [sacl_pkg::COUNT_W-1:0]     hits_so_far;
    logic [sacl_pkg::COUNT_W-1:0]     misses_so_far;
    logic [sacl_pkg::COUNT_W-1:0]     evictions_so_far;
    logic [2:0]                       cfg_set_bits;
    logic [2:0]                       cfg_ways;
    logic [3:0]                       cfg_block_bits;

    sacl_pkg::cache_out_t             pending_results [$];
    int                               error_count;
    int                               send_idle_pct;
    int                               recv_idle_pct;

    set_assoc_cache_lru_sim dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int eff_set_bits();
        return clamp_int(int'(cfg_set_bits), 1, sacl_pkg::MAX_SET_BITS);
    endfunction

    function automatic int eff_block_bits();
        return clamp_int(int'(cfg_block_bits), 1, sacl_pkg::BLOCK_BITS_MAX);
    endfunction

    function automatic void promote_way(input int base, input int nw, input int w,
                                        input bit filling);
        logic [sacl_pkg::RANK_W-1:0] old_rank;
        old_rank = cached_rank[base + w];
        for (int i = 0; i < nw; i++)
        begin
            if (i != w && cached_valid[base + i] &&
                (filling || cached_rank[base + i] < old_rank))
            begin
                if (cached_rank[base + i] < sacl_pkg::RANK_MAX)
                    cached_rank[base + i] = cached_rank[base + i] + 1'b1;
            end
        end
        cached_rank[base + w] = '0;
    endfunction

    function automatic sacl_pkg::outcome_t access_line(
        input logic [sacl_pkg::ADDRESS_W-1:0] addr);
        int                             sb;
        int                             nw;
        int                             bb;
        int                             base;
        int                             victim;
        logic [sacl_pkg::ADDRESS_W-1:0] shifted;
        logic [sacl_pkg::TAG_W-1:0]     line_tag;
        sb = eff_set_bits();
        nw = clamp_int(int'(cfg_ways), 1, sacl_pkg::NUM_WAYS);
        bb = eff_block_bits();
        shifted = (addr & sacl_pkg::ADDR_MASK) >> bb;
        base = int'(shifted & ((32'd1 << sb) - 32'd1)) * sacl_pkg::NUM_WAYS;
        line_tag = sacl_pkg::TAG_W'(shifted >> sb);
        for (int i = 0; i < nw; i++)
        begin
            if (cached_valid[base + i] && cached_tag[base + i] == line_tag)
            begin
                hits_so_far = hits_so_far + 1;
                promote_way(base, nw, i, 1'b0);
                return sacl_pkg::OUT_HIT;
            end
        end
        for (int i = 0; i < nw; i++)
        begin
            if (!cached_valid[base + i])
            begin
                misses_so_far = misses_so_far + 1;
                cached_valid[base + i] = 1'b1;
                cached_tag[base + i] = line_tag;
                promote_way(base, nw, i, 1'b1);
                return sacl_pkg::OUT_MISS;
            end
        end
        misses_so_far = misses_so_far + 1;
        evictions_so_far = evictions_so_far + 1;
        victim = 0;
        for (int i = 1; i < nw; i++)
        begin
            if (cached_rank[base + i] > cached_rank[base + victim])
                victim = i;
        end
        cached_tag[base + victim] = line_tag;
        promote_way(base, nw, victim, 1'b0);
        return sacl_pkg::OUT_EVICT;
    endfunction

    function automatic void expect_access(input sacl_pkg::op_t op,
                                          input logic [sacl_pkg::ADDRESS_W-1:0] addr);
        sacl_pkg::cache_out_t res;
        if (op == sacl_pkg::OP_IFETCH)
            return;
        if (op == sacl_pkg::OP_MODIFY)
        begin
            res.outcome        = access_line(addr);
            res.hit_total      = hits_so_far;
            res.miss_total     = misses_so_far;
            res.eviction_total = evictions_so_far;
            res.last_of_item   = 1'b0;
            pending_results.push_back(res);
        end
        res.outcome        = access_line(addr);
        res.hit_total      = hits_so_far;
        res.miss_total     = misses_so_far;
        res.eviction_total = evictions_so_far;
        res.last_of_item   = 1'b1;
        pending_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        sacl_pkg::cache_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 32'(out_data.outcome), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (out_data.outcome != want.outcome)
                    report_mismatch("outcome", 32'(out_data.outcome), 32'(want.outcome));
                if (out_data.hit_total != want.hit_total)
                    report_mismatch("hit_total", out_data.hit_total, want.hit_total);
                if (out_data.miss_total != want.miss_total)
                    report_mismatch("miss_total", out_data.miss_total, want.miss_total);
                if (out_data.eviction_total != want.eviction_total)
                    report_mismatch("eviction_total", out_data.eviction_total,
                                    want.eviction_total);
                if (out_data.last_of_item != want.last_of_item)
                    report_mismatch("last_of_item", 32'(out_data.last_of_item),
                                    32'(want.last_of_item));
            end
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic send_access(input sacl_pkg::op_t op,
                               input logic [sacl_pkg::ADDRESS_W-1:0] addr);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= '{operation: op, address: addr};
        expect_access(op, addr);
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (6) @(posedge clk);
    endtask

    task automatic write_config(input logic [3:0] sb, input logic [3:0] ways,
                                input logic [3:0] bb);
        cfg_write <= 1'b1;
        cfg_index <= sacl_pkg::CFG_SET_BITS;
        cfg_data  <= sb;
        @(posedge clk);
        cfg_index <= sacl_pkg::CFG_WAYS_IN_USE;
        cfg_data  <= ways;
        @(posedge clk);
        cfg_index <= sacl_pkg::CFG_BLOCK_BITS;
        cfg_data  <= bb;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_set_bits   = sb[2:0];
        cfg_ways       = ways[2:0];
        cfg_block_bits = bb;
    endtask

    task automatic test_single_way_basics();
        settle();
        write_config(4'd1, 4'd1, 4'd1);
        send_access(sacl_pkg::OP_LOAD, 32'h0000_0000);
        send_access(sacl_pkg::OP_STORE, 32'h0000_0001);
        send_access(sacl_pkg::OP_LOAD, 32'h0000_0002);
        send_access(sacl_pkg::OP_IFETCH, 32'h0000_0000);
        send_access(sacl_pkg::OP_MODIFY, 32'h0000_0004);
        send_access(sacl_pkg::OP_LOAD, 32'hFFFF_FFFF);
        send_access(sacl_pkg::OP_STORE, 32'h0000_0000);
    endtask

    task automatic test_lru_replacement();
        logic [sacl_pkg::ADDRESS_W-1:0] set_part;
        set_part = (32'd3 << 9) | 32'h1FF;
        settle();
        write_config(4'd5, 4'd4, 4'd9);
        for (int t = 1; t <= 4; t++)
            send_access(sacl_pkg::OP_LOAD, (32'(t) << 14) | set_part);
        send_access(sacl_pkg::OP_LOAD, (32'd1 << 14) | set_part);
        send_access(sacl_pkg::OP_STORE, (32'd5 << 14) | set_part);
        send_access(sacl_pkg::OP_LOAD, (32'd2 << 14) | set_part);
        send_access(sacl_pkg::OP_MODIFY, (32'd3 << 14) | set_part);
    endtask

    task automatic test_register_saturation();
        settle();
        write_config(4'd0, 4'd0, 4'd0);
        send_access(sacl_pkg::OP_LOAD, 32'h8000_0001);
        send_access(sacl_pkg::OP_MODIFY, 32'h8000_0000);
        settle();
        write_config(4'd15, 4'd15, 4'd15);
        send_access(sacl_pkg::OP_LOAD, 32'hFFFF_FFFF);
    endtask

    // Narrowing and widening the ways ties two ranks; the miss must fill the invalid way.
    task automatic test_victim_tie();
        settle();
        write_config(4'd1, 4'd2, 4'd1);
        send_access(sacl_pkg::OP_LOAD, 32'h0000_0006);
        settle();
        write_config(4'd1, 4'd1, 4'd1);
        send_access(sacl_pkg::OP_LOAD, 32'h0000_000A);
        settle();
        write_config(4'd1, 4'd2, 4'd1);
        send_access(sacl_pkg::OP_LOAD, 32'h0000_000E);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input bit pause_once);
        logic [sacl_pkg::ADDRESS_W-1:0] tag_pool [6];
        logic [sacl_pkg::ADDRESS_W-1:0] addr;
        sacl_pkg::op_t                  op;
        int                             sent;
        int                             sb;
        int                             bb;
        for (int c = 0; c < 3; c++)
        begin
            settle();
            if (c == 2)
                write_config(4'd5, 4'd4, 4'd9);
            else if ($urandom_range(0, 3) == 0)
                write_config(4'($urandom), 4'($urandom), 4'($urandom));
            else
                write_config(4'($urandom_range(1, 5)), 4'($urandom_range(1, 4)),
                             4'($urandom_range(1, 9)));
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            foreach (tag_pool[i])
                tag_pool[i] = $urandom;
            sb = eff_set_bits();
            bb = eff_block_bits();
            sent = 0;
            while (sent < 50)
            begin
                op = sacl_pkg::op_t'($urandom_range(0, 3));
                if ($urandom_range(0, 9) < 8)
                    addr = (tag_pool[$urandom_range(0, 5)] << (sb + bb)) |
                           (32'($urandom_range(0, 3)) << bb) |
                           ($urandom & ((32'd1 << bb) - 32'd1));
                else
                    addr = $urandom;
                send_access(op, addr);
                sent++;
                if (pause_once && c == 1 && sent == 25)
                    hold_until_drained();
            end
        end
    endtask

    initial
    begin : main_sequence
        int guard;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= sacl_pkg::CFG_SET_BITS;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        for (int i = 0; i < LINES; i++)
        begin
            cached_valid[i] = 1'b0;
            cached_tag[i]   = '0;
            cached_rank[i]  = '0;
        end
        hits_so_far      = '0;
        misses_so_far    = '0;
        evictions_so_far = '0;
        cfg_set_bits     = 3'd1;
        cfg_ways         = 3'd1;
        cfg_block_bits   = 4'd1;
        error_count      = 0;
        send_idle_pct    = 9;
        recv_idle_pct    = 58;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_way_basics();
        test_lru_replacement();
        test_register_saturation();
        test_victim_tie();
        test_random_traffic(9, 58, 1'b1);
        test_random_traffic(58, 9, 1'b0);
        test_random_traffic(0, 0, 1'b0);

        in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 32'(pending_results.size()), 32'd0);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
